@@ hdl/bnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, codes and bracket decode for the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int unsigned StatusW = 2;
  localparam int unsigned ScoreW  = 63;
  localparam int unsigned TotalW  = 32;

  localparam logic [StatusW-1:0] ST_COMPLETE  = 2'd0;
  localparam logic [StatusW-1:0] ST_MISMATCH  = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [StatusW-1:0] ST_CORRUPTED = 2'd3;

  localparam logic [ScoreW-1:0] SCORE_MAX = {ScoreW{1'b1}};
  localparam logic [TotalW-1:0] TOTAL_MAX = {TotalW{1'b1}};

  typedef logic [1:0] code_t;

  typedef struct packed {
    logic              is_open;
    logic              is_close;
    code_t             code;
  } bracket_t;

  typedef struct packed {
    logic [TotalW-1:0]  error_total;
    logic [ScoreW-1:0]  score;
    logic [StatusW-1:0] status;
  } result_t;

  function automatic bracket_t decode_char(input logic [7:0] c);
    bracket_t b;
    b = '{is_open: 1'b0, is_close: 1'b0, code: 2'd0};
    unique case (c)
      8'h28: b = '{is_open: 1'b1, is_close: 1'b0, code: 2'd0}; // (
      8'h5b: b = '{is_open: 1'b1, is_close: 1'b0, code: 2'd1}; // [
      8'h7b: b = '{is_open: 1'b1, is_close: 1'b0, code: 2'd2}; // {
      8'h3c: b = '{is_open: 1'b1, is_close: 1'b0, code: 2'd3}; // <
      8'h29: b = '{is_open: 1'b0, is_close: 1'b1, code: 2'd0}; // )
      8'h5d: b = '{is_open: 1'b0, is_close: 1'b1, code: 2'd1}; // ]
      8'h7d: b = '{is_open: 1'b0, is_close: 1'b1, code: 2'd2}; // }
      8'h3e: b = '{is_open: 1'b0, is_close: 1'b1, code: 2'd3}; // >
      default: b = '{is_open: 1'b0, is_close: 1'b0, code: 2'd0};
    endcase
    return b;
  endfunction

  function automatic logic [14:0] close_points(input code_t c);
    logic [14:0] p;
    unique case (c)
      2'd0: p = 15'd3;
      2'd1: p = 15'd57;
      2'd2: p = 15'd1197;
      2'd3: p = 15'd25137;
      default: p = 15'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/bnc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bnc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bracket_nesting_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_nesting_checker_top
// Stack-based bracket matcher with error points and completion scores.
// ----------------------------------------------------------------------------
// Beats that leave no result keep the checker in its idle state: openers,
// ignored bytes, bytes on a corrupted line and a matching closer that empties
// the stack. A matching closer that leaves openers on the stack passes through
// the refill state, where the new top of stack is read back from the stack RAM
// into the cached top register. A beat that makes a result holds the input
// until the result leaves the holding stage for the output register, as soon
// as the output is free and not while it is stalled. End of line on a clean
// line holding openers passes through the drain state, one stack RAM read per
// opener while the base-5 score is built. The stack RAM needs no clearing
// after reset.
module bracket_nesting_checker_top
  import bnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [0] command, [8:1] ch, [15:9] zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // [1:0] status, [64:2] score, [96:65] error_total
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REFILL = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     count;
  logic              corrupted;
  logic [TotalW-1:0] esum;
  code_t             top;
  logic [CW-1:0]     rd_left;
  logic [ScoreW-1:0] acc;
  logic              res_valid;
  result_t           res;
  result_t           out;

  logic              accept;
  logic              command;
  bracket_t          br;
  logic              we;
  logic [AW-1:0]     raddr;
  code_t             rdata;
  logic [32:0]       esum_add;
  logic [TotalW-1:0] esum_next;
  logic [65:0]       acc_wide;
  logic [ScoreW-1:0] acc_next;

  assign command  = s_tdata[0];
  assign br       = decode_char(s_tdata[8:1]);
  assign s_tready = (state == S_IDLE) && !res_valid;
  assign accept   = s_tvalid && s_tready;

  assign esum_add  = {1'b0, esum} + {18'd0, close_points(br.code)};
  assign esum_next = esum_add[32] ? TOTAL_MAX : esum_add[TotalW-1:0];

  // score * 5 + (code + 1), saturating
  assign acc_wide = {1'b0, acc, 2'b00} + {3'd0, acc} + {63'd0, 1'b0, rdata} + 66'd1;
  assign acc_next = (|acc_wide[65:63]) ? SCORE_MAX : acc_wide[ScoreW-1:0];

  assign we = accept && !command && !corrupted && br.is_open && (count < FULL);

  always_comb begin
    raddr = '0;
    priority if (state == S_DRAIN) begin
      raddr = AW'(rd_left - CW'(1));
    end else if (accept && command) begin
      raddr = AW'(count - CW'(1));
    end else begin
      raddr = AW'(count - CW'(2));
    end
  end

  bnc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (br.code),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      corrupted <= 1'b0;
      esum      <= '0;
      res_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (res_valid && (!m_tvalid || m_tready)) begin
        out       <= res;
        m_tvalid  <= 1'b1;
        res_valid <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (command) begin
              if (corrupted || (count == '0)) begin
                res_valid <= 1'b1;
                res       <= '{error_total: esum, score: '0,
                               status: corrupted ? ST_CORRUPTED : ST_COMPLETE};
                count     <= '0;
                corrupted <= 1'b0;
              end else begin
                rd_left <= count - CW'(1);
                acc     <= '0;
                state   <= S_DRAIN;
              end
            end else if (!corrupted) begin
              if (br.is_open) begin
                if (count >= FULL) begin
                  corrupted <= 1'b1;
                  res_valid <= 1'b1;
                  res       <= '{error_total: esum, score: '0, status: ST_OVERFLOW};
                end else begin
                  top   <= br.code;
                  count <= count + CW'(1);
                end
              end else if (br.is_close) begin
                if ((count == '0) || (top != br.code)) begin
                  esum      <= esum_next;
                  corrupted <= 1'b1;
                  res_valid <= 1'b1;
                  res       <= '{error_total: esum_next,
                                 score: ScoreW'(close_points(br.code)),
                                 status: ST_MISMATCH};
                end else begin
                  count <= count - CW'(1);
                  if (count > CW'(1)) begin
                    state <= S_REFILL;
                  end
                end
              end
            end
          end
        end
        S_REFILL: begin
          top   <= rdata;
          state <= S_IDLE;
        end
        S_DRAIN: begin
          acc <= acc_next;
          if (rd_left != '0) begin
            rd_left <= rd_left - CW'(1);
          end else begin
            res_valid <= 1'b1;
            res       <= '{error_total: esum, score: acc_next, status: ST_COMPLETE};
            count     <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, out};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL) else $error("stack count beyond depth");

  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (!corrupted && count != '0 && rd_left < count))
    else $error("drain on corrupted or empty line");

  a_refill_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL) |-> (count != '0)) else $error("refill with empty stack");

  a_esum_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (esum >= $past(esum))) else $error("error sum decreased");

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (!m_tvalid || m_tready)) |=> (m_tvalid && !res_valid))
    else $error("held result not moved to output");
`endif

endmodule
